### src/qvr_pkg.sv
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 18;
    localparam int CFG_W     = 14;
    localparam int SQ_W      = 32;
    localparam int SUM_W     = 33;
    localparam int LEN_W     = 17;
    localparam int SQ_DIGITS = 17;
    localparam int SQ_LAT    = SQ_DIGITS + 1;
    localparam int NUM_W     = 31;
    localparam int DEN_W     = 18;
    localparam int QUO_W     = 15;
    localparam int DIV_LAT   = QUO_W;
    localparam int T_W       = 19;
    localparam int ACC_W     = 38;
    localparam int ROT_LAT   = 5;
    localparam int PIPE_LAT  = 2 + SQ_LAT + 1 + DIV_LAT + 1 + ROT_LAT;

    typedef logic signed [IN_W-1:0]  comp_t;
    typedef logic signed [OUT_W-1:0] rot_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // round to nearest, ties away from zero, drop FRAC_BITS
    function automatic acc_t rnd_shift(input acc_t x);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] m;
        begin
            mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
            m   = (mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            rnd_shift = x[ACC_W-1] ? acc_t'(-m) : acc_t'(m);
        end
    endfunction

    function automatic rot_t sat_out(input acc_t x);
        acc_t hi;
        acc_t lo;
        begin
            hi = acc_t'((1 <<< (OUT_W - 1)) - 1);
            lo = -acc_t'(1 <<< (OUT_W - 1));
            if (x > hi)
                sat_out = rot_t'(hi);
            else if (x < lo)
                sat_out = rot_t'(lo);
            else
                sat_out = x[OUT_W-1:0];
        end
    endfunction

endpackage

### src/qvr_delay.sv
`timescale 1ns / 1ps

module qvr_delay
    import qvr_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

### src/qvr_isqrt.sv
`timescale 1ns / 1ps

module qvr_isqrt
    import qvr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [SUM_W-1:0] s,
    output logic [LEN_W-1:0] len
);

    localparam int SW    = 2 * SQ_DIGITS;
    localparam int REM_W = LEN_W + 4;

    logic [SW-1:0]    s_reg    [SQ_DIGITS];
    logic [LEN_W-1:0] root_reg [SQ_DIGITS];
    logic [REM_W-1:0] rem_reg  [SQ_DIGITS];
    logic [LEN_W-1:0] len_reg;

    // one result digit per stage
    for (genvar k = 0; k < SQ_DIGITS; k++)
    begin : g_dig
        logic [SW-1:0]    s_src;
        logic [LEN_W-1:0] root_src;
        logic [REM_W-1:0] rem_src;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign s_src    = SW'(s);
            assign root_src = '0;
            assign rem_src  = '0;
        end
        else
        begin : g_next
            assign s_src    = s_reg[k-1];
            assign root_src = root_reg[k-1];
            assign rem_src  = rem_reg[k-1];
        end

        assign rem_sh = {rem_src[REM_W-3:0], s_src[SW-1-2*k -: 2]};
        assign trial  = REM_W'({root_src, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k] <= s_src;
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_src[LEN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_src[LEN_W-2:0], 1'b0};
                end
            end
        end
    end

    // round: floor root, bump when remainder exceeds root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_reg[SQ_DIGITS-1] > REM_W'(root_reg[SQ_DIGITS-1]))
                len_reg <= root_reg[SQ_DIGITS-1] + LEN_W'(1);
            else
                len_reg <= root_reg[SQ_DIGITS-1];
        end
    end

    assign len = len_reg;

endmodule

### src/qvr_div.sv
`timescale 1ns / 1ps

module qvr_div
    import qvr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] p_reg [QUO_W];
    logic [QUO_W-1:0] n_reg [QUO_W];
    logic [DEN_W-1:0] d_reg [QUO_W];
    logic [QUO_W-1:0] q_reg [QUO_W];

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_bit
        logic [DEN_W-1:0] p_src;
        logic [QUO_W-1:0] n_src;
        logic [DEN_W-1:0] d_src;
        logic [QUO_W-1:0] q_src;
        logic [DEN_W:0]   p2;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign p_src = DEN_W'(num[NUM_W-1:QUO_W]);
            assign n_src = num[QUO_W-1:0];
            assign d_src = den;
            assign q_src = '0;
        end
        else
        begin : g_next
            assign p_src = p_reg[j-1];
            assign n_src = n_reg[j-1];
            assign d_src = d_reg[j-1];
            assign q_src = q_reg[j-1];
        end

        assign p2   = {p_src, n_src[QUO_W-1-j]};
        assign ge   = p2 >= {1'b0, d_src};
        assign diff = p2 - {1'b0, d_src};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[j] <= ge ? diff[DEN_W-1:0] : p2[DEN_W-1:0];
                n_reg[j] <= n_src;
                d_reg[j] <= d_src;
                q_reg[j] <= {q_src[QUO_W-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QUO_W-1];

endmodule

### src/qvr_rotate.sv
`timescale 1ns / 1ps

module qvr_rotate
    import qvr_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  comp_t qn [4],
    input  comp_t v [3],
    input  logic  degen,
    output rot_t  rot [3],
    output logic  degen_out
);

    localparam int P_W = 2 * IN_W;
    localparam int M_W = IN_W + T_W;

    // R1: q x v partial products
    logic signed [P_W-1:0] p_reg [6];
    comp_t                 qn1_reg [4];
    comp_t                 v1_reg [3];
    logic                  dg1_reg;
    // R2: t = 2 (q x v)
    logic signed [T_W-1:0] t_reg [3];
    comp_t                 qn2_reg [4];
    comp_t                 v2_reg [3];
    logic                  dg2_reg;
    // R3: q x t, w t
    logic signed [M_W-1:0] m_reg [6];
    logic signed [M_W-1:0] wt_reg [3];
    comp_t                 v3_reg [3];
    logic                  dg3_reg;
    // R4: sum
    acc_t                  acc_reg [3];
    comp_t                 v4_reg [3];
    logic                  dg4_reg;
    // R5: output
    rot_t                  rot_reg [3];
    logic                  dg5_reg;

    acc_t t_full [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_t
        assign t_full[i] = rnd_shift(acc_t'(p_reg[2*i] - p_reg[2*i+1]) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= qn[1] * v[2];
            p_reg[1] <= qn[2] * v[1];
            p_reg[2] <= qn[2] * v[0];
            p_reg[3] <= qn[0] * v[2];
            p_reg[4] <= qn[0] * v[1];
            p_reg[5] <= qn[1] * v[0];
            qn1_reg  <= qn;
            v1_reg   <= v;
            dg1_reg  <= degen;

            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= t_full[i][T_W-1:0];
            end
            qn2_reg <= qn1_reg;
            v2_reg  <= v1_reg;
            dg2_reg <= dg1_reg;

            m_reg[0] <= qn2_reg[1] * t_reg[2];
            m_reg[1] <= qn2_reg[2] * t_reg[1];
            m_reg[2] <= qn2_reg[2] * t_reg[0];
            m_reg[3] <= qn2_reg[0] * t_reg[2];
            m_reg[4] <= qn2_reg[0] * t_reg[1];
            m_reg[5] <= qn2_reg[1] * t_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                wt_reg[i] <= qn2_reg[3] * t_reg[i];
            end
            v3_reg  <= v2_reg;
            dg3_reg <= dg2_reg;

            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= (acc_t'(v3_reg[i]) <<< FRAC_BITS) + acc_t'(wt_reg[i])
                            + acc_t'(m_reg[2*i]) - acc_t'(m_reg[2*i+1]);
            end
            v4_reg  <= v3_reg;
            dg4_reg <= dg3_reg;

            for (int i = 0; i < 3; i++)
            begin
                rot_reg[i] <= dg4_reg ? rot_t'(v4_reg[i]) : sat_out(rnd_shift(acc_reg[i]));
            end
            dg5_reg <= dg4_reg;
        end
    end

    assign rot       = rot_reg;
    assign degen_out = dg5_reg;

endmodule

### src/quaternion_vector_rotate.sv
`timescale 1ns / 1ps

// Quaternion vector rotation, fixed point.
// Input word: quaternion quat_x/y/z/w and vector vec_x/y/z, signed Q2.14.
// Output word: rot_x/y/z, signed Q4.14 saturated, plus degenerate, set when
//   the rounded quaternion length is at or below min_length and the vector
//   was passed through unchanged.
// Channels use valid/stall; a word moves on a clock edge with valid high and
//   stall low. cfg_we/cfg_data load min_length; write it only while idle.
// Throughput: one word per cycle while a held output word does not stall the pipe.
// The pipe depth is set by the square root (17 digit stages plus rounding)
//   and the four parallel normalizing dividers (15 quotient-bit stages each).
// Stall: the whole pipe freezes while the output word is held by stall;
//   in_stall then follows out_stall. Bubbles move on otherwise.
// Reset: valid bits, min_length and the side delay lines clear; other payload registers are not reset.

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] quat_x,
    input  logic signed [IN_W-1:0] quat_y,
    input  logic signed [IN_W-1:0] quat_z,
    input  logic signed [IN_W-1:0] quat_w,
    input  logic signed [IN_W-1:0] vec_x,
    input  logic signed [IN_W-1:0] vec_y,
    input  logic signed [IN_W-1:0] vec_z,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [OUT_W-1:0] rot_x,
    output logic signed [OUT_W-1:0] rot_y,
    output logic signed [OUT_W-1:0] rot_z,
    output logic                   degenerate
);

    localparam int SIDE_W = 4 * IN_W + 4 + 3 * IN_W;
    localparam int DSID_W = 4 + 3 * IN_W + 1;

    logic             en;
    logic [CFG_W-1:0] min_len_reg;

    comp_t q_in [4];
    comp_t v_in [3];

    // stage 1: squares, magnitudes
    logic [SQ_W-1:0] sq_reg   [4];
    logic [IN_W-1:0] absq_reg [4];
    logic [3:0]      sgn_reg;
    comp_t           v1_reg   [3];
    // stage 2: sum of squares
    logic [SUM_W-1:0] s_reg;
    logic [IN_W-1:0]  absq2_reg [4];
    logic [3:0]       sgn2_reg;
    comp_t            v2_reg    [3];

    logic [LEN_W-1:0] len;
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] side_out;
    logic [IN_W-1:0]  absq_d [4];
    logic [3:0]       sgn_d;
    comp_t            v_d   [3];

    // stage 3: threshold and divider operands
    logic [NUM_W-1:0] num_reg [4];
    logic [DEN_W-1:0] den_reg;
    logic             degen_reg;
    logic [3:0]       sgn3_reg;
    comp_t            v3_reg  [3];

    logic [QUO_W-1:0]  quo [4];
    logic [DSID_W-1:0] dside_in;
    logic [DSID_W-1:0] dside_out;

    // stage 4: signed normalized quaternion
    comp_t qn_reg [4];
    comp_t v4_reg [3];
    logic  dg4_reg;

    rot_t rot [3];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign q_in = '{quat_x, quat_y, quat_z, quat_w};
    assign v_in = '{vec_x, vec_y, vec_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= '0;
        else if (cfg_we)
            min_len_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i]   <= SQ_W'(q_in[i] * q_in[i]);
                absq_reg[i] <= q_in[i][IN_W-1] ? IN_W'(-q_in[i]) : IN_W'(q_in[i]);
                sgn_reg[i]  <= q_in[i][IN_W-1];
            end
            v1_reg <= v_in;

            s_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                   + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
            absq2_reg <= absq_reg;
            sgn2_reg  <= sgn_reg;
            v2_reg    <= v1_reg;
        end
    end

    qvr_isqrt u_isqrt (
        .clk (clk),
        .en  (en),
        .s   (s_reg),
        .len (len)
    );

    assign side_in = {absq2_reg[0], absq2_reg[1], absq2_reg[2], absq2_reg[3], sgn2_reg,
                      v2_reg[0], v2_reg[1], v2_reg[2]};

    qvr_delay #(.W(SIDE_W), .DEPTH(SQ_LAT)) u_sq_side (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (side_in),
        .dout  (side_out)
    );

    assign {absq_d[0], absq_d[1], absq_d[2], absq_d[3], sgn_d,
            v_d[0], v_d[1], v_d[2]} = side_out;

    // round(|q| * 2^F / len) = floor((2|q| 2^F + len) / (2 len))
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                num_reg[i] <= (NUM_W'(absq_d[i]) << (FRAC_BITS + 1)) + NUM_W'(len);
            end
            den_reg   <= {len, 1'b0};
            degen_reg <= len <= LEN_W'(min_len_reg);
            sgn3_reg  <= sgn_d;
            v3_reg    <= v_d;
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        qvr_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    assign dside_in = {sgn3_reg, v3_reg[0], v3_reg[1], v3_reg[2], degen_reg};

    qvr_delay #(.W(DSID_W), .DEPTH(DIV_LAT)) u_div_side (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (dside_in),
        .dout  (dside_out)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                qn_reg[i] <= dside_out[DSID_W-4+i] ? -comp_t'(quo[i]) : comp_t'(quo[i]);
            end
            v4_reg[0] <= dside_out[3*IN_W:2*IN_W+1];
            v4_reg[1] <= dside_out[2*IN_W:IN_W+1];
            v4_reg[2] <= dside_out[IN_W:1];
            dg4_reg   <= dside_out[0];
        end
    end

    qvr_rotate u_rotate (
        .clk       (clk),
        .en        (en),
        .qn        (qn_reg),
        .v         (v4_reg),
        .degen     (dg4_reg),
        .rot       (rot),
        .degen_out (degenerate)
    );

    // valid bits run alongside the data
    qvr_delay #(.W(1), .DEPTH(PIPE_LAT)) u_valid (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (in_valid),
        .dout  (out_valid)
    );

    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

endmodule

### src/qvr_checker.sv
`timescale 1ns / 1ps

module qvr_checker
    import qvr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [OUT_W-1:0] rot_x,
    input  logic                    degenerate
);

    // held output word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(rot_x) && $stable(degenerate))
        else $error("output word changed while stalled");

    // pipe freezes only behind a held output word
    a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while pipe frozen");

    a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && out_stall) |-> !in_stall)
        else $error("input stalled with free pipe");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rot_x      (rot_x),
    .degenerate (degenerate)
);
